// ===== hw/rtl/sbfc_pkg.sv =====
// ----------------------------------------------------------------------------
// sbfc_pkg
// Shared widths, byte codes and types for the bulk-dump frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package sbfc_pkg;

    // Frame geometry
    localparam int PAYLOAD_BYTES = 4096;
    localparam int VOICE_BYTES   = 128;

    localparam int CNT_W  = $clog2(PAYLOAD_BYTES);
    localparam int VOFF_W = $clog2(VOICE_BYTES);

    // Field widths
    localparam int DATA_W  = 8;
    localparam int PB_W    = 7;
    localparam int VIDX_W  = 5;
    localparam int VOFS_W  = 7;
    localparam int ERR_W   = 3;
    localparam int CHAN_W  = 4;

    // Byte codes
    localparam logic [DATA_W-1:0] START_BYTE = 8'hF0;
    localparam logic [DATA_W-1:0] END_BYTE   = 8'hF7;
    localparam logic [DATA_W-1:0] MFR_ID     = 8'h43;
    localparam logic [DATA_W-1:0] CHAN_MAX   = 8'h0F;
    localparam logic [DATA_W-1:0] FMT_BYTE   = 8'h04;
    localparam logic [DATA_W-1:0] CNT_HI     = 8'h20;
    localparam logic [DATA_W-1:0] CNT_LO     = 8'h00;

    // Header byte positions after the start byte
    localparam logic [2:0] HDR_POS_ID   = 3'd1;
    localparam logic [2:0] HDR_POS_CHAN = 3'd2;
    localparam logic [2:0] HDR_POS_FMT  = 3'd3;
    localparam logic [2:0] HDR_POS_CHI  = 3'd4;
    localparam logic [2:0] HDR_POS_CLO  = 3'd5;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 3'd0,
        ERR_HEADER   = 3'd1,
        ERR_STATUS   = 3'd2,
        ERR_CHECKSUM = 3'd3,
        ERR_END      = 3'd4
    } t_err;

    typedef enum logic [4:0] {
        PH_HUNT = 5'b00001,
        PH_HDR  = 5'b00010,
        PH_DATA = 5'b00100,
        PH_CSUM = 5'b01000,
        PH_TAIL = 5'b10000
    } t_phase;

    typedef struct packed {
        logic              payload_valid;
        logic [PB_W-1:0]   payload_byte;
        logic [VIDX_W-1:0] voice_index;
        logic [VOFS_W-1:0] voice_offset;
        logic              frame_done;
        t_err              error_code;
        logic [CHAN_W-1:0] device_channel;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/sbfc_if.sv =====
// ----------------------------------------------------------------------------
// sbfc_if
// Valid/ready channels for raw bytes in and tagged results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbfc_in_if;
    import sbfc_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface sbfc_out_if;
    import sbfc_pkg::*;

    logic              valid;
    logic              ready;
    logic              payload_valid;
    logic [PB_W-1:0]   payload_byte;
    logic [VIDX_W-1:0] voice_index;
    logic [VOFS_W-1:0] voice_offset;
    logic              frame_done;
    logic [ERR_W-1:0]  error_code;
    logic [CHAN_W-1:0] device_channel;

    modport source (
        output valid, output payload_valid, output payload_byte,
        output voice_index, output voice_offset, output frame_done,
        output error_code, output device_channel, input ready
    );
    modport sink (
        input valid, input payload_valid, input payload_byte,
        input voice_index, input voice_offset, input frame_done,
        input error_code, input device_channel, output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/sysex_bulk_frame_checker_core.sv =====
// ----------------------------------------------------------------------------
// sysex_bulk_frame_checker_core
// Frame checker for a system-exclusive bulk voice dump, one byte per request.
// ----------------------------------------------------------------------------
// Takes one raw byte per request and returns exactly one result per byte.
// A new byte is taken every cycle while the output side is not stalled; each
// byte passes an input register and a result register before its result is on
// the outputs. The rate is set by the frame state update (phase, counters,
// running checksum). The block hunts for 0xF0, checks the five header bytes,
// tags each payload byte with its voice record index and offset, checks the
// 7-bit checksum and the closing 0xF7. Any failure ends the frame with an
// error code and the next byte starts the hunt again.
`default_nettype none

module sysex_bulk_frame_checker_core (
    input  wire  i_clk,
    input  wire  i_rst_n,
    sbfc_in_if.sink    i_in,
    sbfc_out_if.source o_out
);
    import sbfc_pkg::*;

    logic              r_in_valid;
    logic [DATA_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;

    t_phase            r_phase,  n_phase;
    logic [2:0]        r_hpos,   n_hpos;
    logic [CNT_W-1:0]  r_cnt,    n_cnt;
    logic [VOFF_W-1:0] r_voff,   n_voff;
    logic [VIDX_W-1:0] r_vidx,   n_vidx;
    logic [PB_W-1:0]   r_sum,    n_sum;
    logic [CHAN_W-1:0] r_chan,   n_chan;
    t_result           n_out;

    logic advance;
    logic step;
    logic hdr_ok;
    logic [PB_W-1:0] csum;

    assign advance    = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    always_comb begin
        case (r_hpos)
            HDR_POS_ID:   hdr_ok = (r_in_byte == MFR_ID);
            HDR_POS_CHAN: hdr_ok = (r_in_byte <= CHAN_MAX);
            HDR_POS_FMT:  hdr_ok = (r_in_byte == FMT_BYTE);
            HDR_POS_CHI:  hdr_ok = (r_in_byte == CNT_HI);
            HDR_POS_CLO:  hdr_ok = (r_in_byte == CNT_LO);
            default:      hdr_ok = 1'b0;
        endcase
    end

    assign csum = r_sum + r_in_byte[PB_W-1:0];

    always_comb begin
        n_phase = r_phase;
        n_hpos  = r_hpos;
        n_cnt   = r_cnt;
        n_voff  = r_voff;
        n_vidx  = r_vidx;
        n_sum   = r_sum;
        n_chan  = r_chan;
        n_out   = '0;
        n_out.error_code = ERR_NONE;

        case (r_phase)
            PH_HUNT: begin
                if (r_in_byte == START_BYTE) begin
                    n_phase = PH_HDR;
                    n_hpos  = HDR_POS_ID;
                    n_sum   = '0;
                end
            end
            PH_HDR: begin
                if (!hdr_ok) begin
                    n_out.frame_done = 1'b1;
                    n_out.error_code = ERR_HEADER;
                    n_phase          = PH_HUNT;
                end else begin
                    if (r_hpos == HDR_POS_CHAN) begin
                        n_chan = r_in_byte[CHAN_W-1:0];
                    end
                    if (r_hpos == HDR_POS_CLO) begin
                        n_phase = PH_DATA;
                        n_cnt   = '0;
                        n_voff  = '0;
                        n_vidx  = '0;
                    end
                    n_hpos = r_hpos + 3'd1;
                end
            end
            PH_DATA: begin
                if (r_in_byte[DATA_W-1]) begin
                    n_out.frame_done = 1'b1;
                    n_out.error_code = ERR_STATUS;
                    n_phase          = PH_HUNT;
                end else begin
                    n_out.payload_valid = 1'b1;
                    n_out.payload_byte  = r_in_byte[PB_W-1:0];
                    n_out.voice_index   = r_vidx;
                    n_out.voice_offset  = VOFS_W'(r_voff);
                    n_sum               = csum;
                    n_cnt               = r_cnt + 1'b1;
                    if (r_voff == VOFF_W'(VOICE_BYTES - 1)) begin
                        n_voff = '0;
                        n_vidx = r_vidx + 1'b1;
                    end else begin
                        n_voff = r_voff + 1'b1;
                    end
                    if (r_cnt == CNT_W'(PAYLOAD_BYTES - 1)) begin
                        n_phase = PH_CSUM;
                    end
                end
            end
            PH_CSUM: begin
                // Only the low seven bits of the checksum byte count.
                if (csum != '0) begin
                    n_out.frame_done = 1'b1;
                    n_out.error_code = ERR_CHECKSUM;
                    n_phase          = PH_HUNT;
                end else begin
                    n_phase = PH_TAIL;
                end
            end
            PH_TAIL: begin
                n_out.frame_done = 1'b1;
                n_out.error_code = (r_in_byte == END_BYTE) ? ERR_NONE : ERR_END;
                n_phase          = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase

        n_out.device_channel = n_chan;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_HUNT;
            r_chan      <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_phase <= n_phase;
                r_chan  <= n_chan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
        end
        if (step) begin
            r_hpos <= n_hpos;
            r_cnt  <= n_cnt;
            r_voff <= n_voff;
            r_vidx <= n_vidx;
            r_sum  <= n_sum;
            r_out  <= n_out;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.payload_valid  = r_out.payload_valid;
    assign o_out.payload_byte   = r_out.payload_byte;
    assign o_out.voice_index    = r_out.voice_index;
    assign o_out.voice_offset   = r_out.voice_offset;
    assign o_out.frame_done     = r_out.frame_done;
    assign o_out.error_code     = r_out.error_code;
    assign o_out.device_channel = r_out.device_channel;

endmodule

`default_nettype wire

// ===== hw/rtl/sbfc_checker.sv =====
// ----------------------------------------------------------------------------
// sbfc_checker
// Port-level checks on the frame checker's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sbfc_checker (
    input wire                      i_clk,
    input wire                      i_rst_n,
    input wire                      i_out_valid,
    input wire                      i_out_ready,
    input wire                      i_payload_valid,
    input wire [sbfc_pkg::PB_W-1:0] i_payload_byte,
    input wire [sbfc_pkg::VIDX_W-1:0] i_voice_index,
    input wire [sbfc_pkg::VOFS_W-1:0] i_voice_offset,
    input wire                      i_frame_done,
    input wire [sbfc_pkg::ERR_W-1:0] i_error_code
);
    import sbfc_pkg::*;

    // A payload byte never ends a frame.
    a_payload_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_payload_valid) |-> (!i_frame_done && i_error_code == ERR_NONE))
        else $error("payload byte flagged as frame end");

    // Error code only carried on the frame-ending result.
    a_err_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_frame_done) |-> (i_error_code == ERR_NONE))
        else $error("error code without frame end");

    // Tags are zero whenever no payload byte is carried.
    a_tags_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_payload_valid) |->
            (i_payload_byte == '0 && i_voice_index == '0 && i_voice_offset == '0))
        else $error("payload tags set on non-payload result");

    // A stalled result stays valid and holds its payload byte and error code.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_payload_byte) && $stable(i_error_code)))
        else $error("stalled result changed");

endmodule

bind sysex_bulk_frame_checker_core sbfc_checker u_sbfc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_payload_valid (o_out.payload_valid),
    .i_payload_byte  (o_out.payload_byte),
    .i_voice_index   (o_out.voice_index),
    .i_voice_offset  (o_out.voice_offset),
    .i_frame_done    (o_out.frame_done),
    .i_error_code    (o_out.error_code)
);

`default_nettype wire

// ===== dv/sysex_dump_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sysex_dump_checker
// Watches both channels of the bulk-dump frame checker. It rebuilds each
// tagged result from the accepted input bytes and compares them in order.
// ----------------------------------------------------------------------------

module sysex_dump_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    sbfc_in_if   i_in_mon,
    sbfc_out_if  i_out_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_result_count,
    output int   o_frames_closed,
    output int   o_dumps_clean
);
    import sbfc_pkg::*;

    // start byte plus five header bytes, then the payload
    localparam int HDR_LEN     = 6;
    localparam int PAYLOAD_END = HDR_LEN + PAYLOAD_BYTES;

    logic              in_frame;
    logic [CNT_W:0]    byte_pos;
    logic [PB_W-1:0]   csum_acc;
    logic [CHAN_W-1:0] chan_reg;

    t_result results_due[$];

    function automatic t_result decode_byte(input logic [DATA_W-1:0] b);
        t_result         r;
        logic            hdr_ok;
        logic [CNT_W:0]  idx;
        logic [PB_W-1:0] sum_chk;
        r = '0;
        hdr_ok = 1'b0;
        if (!in_frame) begin
            if (b == START_BYTE) begin
                in_frame = 1'b1;
                byte_pos = 1;
                csum_acc = '0;
            end
        end else begin
            if (byte_pos < HDR_LEN) begin
                case (byte_pos)
                    HDR_POS_ID:   hdr_ok = (b == MFR_ID);
                    HDR_POS_CHAN: hdr_ok = (b <= CHAN_MAX);
                    HDR_POS_FMT:  hdr_ok = (b == FMT_BYTE);
                    HDR_POS_CHI:  hdr_ok = (b == CNT_HI);
                    HDR_POS_CLO:  hdr_ok = (b == CNT_LO);
                    default:      hdr_ok = 1'b0;
                endcase
                if (!hdr_ok) begin
                    r.frame_done = 1'b1;
                    r.error_code = ERR_HEADER;
                end else if (byte_pos == HDR_POS_CHAN) begin
                    chan_reg = b[CHAN_W-1:0];
                end
            end else if (byte_pos < PAYLOAD_END) begin
                if (b[DATA_W-1]) begin
                    r.frame_done = 1'b1;
                    r.error_code = ERR_STATUS;
                end else begin
                    idx = byte_pos - HDR_LEN;
                    r.payload_valid = 1'b1;
                    r.payload_byte  = b[PB_W-1:0];
                    r.voice_index   = VIDX_W'(idx / VOICE_BYTES);
                    r.voice_offset  = VOFS_W'(idx % VOICE_BYTES);
                    csum_acc        = csum_acc + b[PB_W-1:0];
                end
            end else if (byte_pos == PAYLOAD_END) begin
                // bit 7 of the checksum byte is don't-care
                sum_chk = csum_acc + b[PB_W-1:0];
                if (sum_chk != '0) begin
                    r.frame_done = 1'b1;
                    r.error_code = ERR_CHECKSUM;
                end
            end else begin
                r.frame_done = 1'b1;
                r.error_code = (b == END_BYTE) ? ERR_NONE : ERR_END;
            end
            if (r.frame_done) begin
                in_frame = 1'b0;
                byte_pos = '0;
            end else begin
                byte_pos = byte_pos + 1'b1;
            end
        end
        r.device_channel = chan_reg;
        return r;
    endfunction

    function automatic void check_field(input string name, input int due, input int got);
        if (due != got) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, due, got);
        end
    endfunction

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_result_count  = 0;
        o_frames_closed = 0;
        o_dumps_clean   = 0;
    end

    always @(posedge i_clk) begin
        t_result due;
        if (!i_rst_n) begin
            in_frame = 1'b0;
            byte_pos = '0;
            csum_acc = '0;
            chan_reg = '0;
            results_due.delete();
        end else begin
            // push first so a same-edge result still finds its entry
            if (i_in_mon.valid && i_in_mon.ready)
                results_due.insert(results_due.size(), decode_byte(i_in_mon.data_byte));
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (results_due.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result with nothing outstanding, expected none, got %h",
                             $time, {i_out_mon.payload_valid, i_out_mon.payload_byte,
                                     i_out_mon.voice_index, i_out_mon.voice_offset,
                                     i_out_mon.frame_done, i_out_mon.error_code,
                                     i_out_mon.device_channel});
                end else begin
                    due = results_due.pop_front();
                    o_result_count++;
                    if (due.frame_done) o_frames_closed++;
                    if (due.frame_done && due.error_code == ERR_NONE) o_dumps_clean++;
                    check_field("payload_valid", due.payload_valid, i_out_mon.payload_valid);
                    check_field("payload_byte", due.payload_byte, i_out_mon.payload_byte);
                    check_field("voice_index", due.voice_index, i_out_mon.voice_index);
                    check_field("voice_offset", due.voice_offset, i_out_mon.voice_offset);
                    check_field("frame_done", due.frame_done, i_out_mon.frame_done);
                    check_field("error_code", due.error_code, i_out_mon.error_code);
                    check_field("device_channel", due.device_channel,
                                i_out_mon.device_channel);
                end
            end
        end
        o_pending = results_due.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Byte stream generator for the bulk-dump frame checker: a few hand-made
// frames, then random short frames with junk, header faults and status
// breaks, under three idle mixes.
// ----------------------------------------------------------------------------

module testbench;
    import sbfc_pkg::*;

    localparam int HDR_LEN = 6;
    localparam int PHASE_BYTES = 550;
    localparam int TX_IDLE_PCT [3] = '{14, 76, 0};
    localparam int RX_IDLE_PCT [3] = '{76, 14, 0};

    logic i_clk;
    logic i_rst_n;

    sbfc_in_if  req_if ();
    sbfc_out_if res_if ();

    logic [DATA_W-1:0] sysex_stream[$];
    int phase_start [3];
    int idle_phase;
    int sent;

    int fail_count, pending, result_count, frames_closed, dumps_clean;

    sysex_bulk_frame_checker_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    sysex_dump_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_mon        (req_if),
        .i_out_mon       (res_if),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_result_count  (result_count),
        .o_frames_closed (frames_closed),
        .o_dumps_clean   (dumps_clean)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic add_byte(input logic [DATA_W-1:0] b);
        sysex_stream = {sysex_stream, b};
    endtask

    task automatic push_header(input logic [DATA_W-1:0] chan);
        add_byte(START_BYTE);
        add_byte(MFR_ID);
        add_byte(chan);
        add_byte(FMT_BYTE);
        add_byte(CNT_HI);
        add_byte(CNT_LO);
    endtask

    // short frame: optional junk, header (bad one ends it), some data, status break
    task automatic push_short_frame();
        logic [DATA_W-1:0] hdr [HDR_LEN];
        int n_junk, n_data, bad_pos;
        n_junk = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n_junk) add_byte(8'($urandom_range(0, 255)));
        hdr = '{START_BYTE, MFR_ID, 8'($urandom_range(0, 15)), FMT_BYTE, CNT_HI, CNT_LO};
        if ($urandom_range(99) < 15) begin
            bad_pos = $urandom_range(1, HDR_LEN - 1);
            if (bad_pos == HDR_POS_CHAN)
                hdr[bad_pos] = 8'($urandom_range(16, 255));
            else
                hdr[bad_pos] = hdr[bad_pos] ^ 8'($urandom_range(1, 255));
            for (int k = 0; k <= bad_pos; k++) add_byte(hdr[k]);
            return;
        end
        for (int k = 0; k < HDR_LEN; k++) add_byte(hdr[k]);
        n_data = ($urandom_range(4) == 0) ? $urandom_range(100, 400) : $urandom_range(0, 40);
        repeat (n_data) add_byte(8'($urandom_range(0, 127)));
        add_byte(8'($urandom_range(128, 255)));
    endtask

    task automatic build_stream();
        int target;
        // ignored while hunting
        sysex_stream = '{8'h00, 8'hFF, 8'h7F, 8'h80};
        // channel 15, two payload bytes, broken by a status byte
        push_header(8'h0F);
        add_byte(8'h7F);
        add_byte(8'h00);
        add_byte(8'hFF);
        // channel above range; channel keeps 15
        add_byte(START_BYTE);
        add_byte(MFR_ID);
        add_byte(8'h10);
        // 0xF0 as a bad ID byte closes the frame and is not a new start
        add_byte(START_BYTE);
        add_byte(START_BYTE);
        add_byte(START_BYTE);
        add_byte(MFR_ID);
        add_byte(8'h00);
        add_byte(FMT_BYTE);
        add_byte(CNT_HI);
        add_byte(8'h01);
        for (int p = 0; p < 3; p++) begin
            phase_start[p] = (p == 0) ? 0 : sysex_stream.size();
            target = sysex_stream.size() + PHASE_BYTES;
            while (sysex_stream.size() < target) push_short_frame();
        end
    endtask

    // receiver: ready is redrawn at random every cycle per current mix
    initial begin
        forever begin
            @(posedge i_clk);
            res_if.ready <= ($urandom_range(99) >= RX_IDLE_PCT[idle_phase]);
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.data_byte = '0;
        res_if.ready   = 1'b0;
        idle_phase     = 0;
        sent           = 0;
        build_stream();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sent < sysex_stream.size()) begin
            @(posedge i_clk);
            if (req_if.valid && req_if.ready) sent++;
            idle_phase = (sent >= phase_start[2]) ? 2 : (sent >= phase_start[1]) ? 1 : 0;
            // hold a pending request until it is taken
            if (!(req_if.valid && !req_if.ready)) begin
                if (sent < sysex_stream.size() &&
                    $urandom_range(99) >= TX_IDLE_PCT[idle_phase]) begin
                    req_if.valid     <= 1'b1;
                    req_if.data_byte <= sysex_stream[sent];
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end

        do @(negedge i_clk); while (pending != 0);
        repeat (16) @(posedge i_clk);

        $display("Sent %0d bytes of junk, header faults and broken frames, three idle mixes;",
                 sent);
        $display("%0d results checked, %0d frames closed, %0d closed without error.",
                 result_count, frames_closed, dumps_clean);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
